[rtl/x86d_pkg.sv]
// ----------------------------------------------------------------------------
// x86d_pkg
// Shared types, codes and tables for the byte-serial 8086 subset decoder.
// ----------------------------------------------------------------------------
package x86d_pkg;

    localparam logic [4:0] OP_MOV = 5'd0;
    localparam logic [4:0] OP_ADD = 5'd1;
    localparam logic [4:0] OP_SUB = 5'd2;
    localparam logic [4:0] OP_CMP = 5'd3;

    localparam logic [2:0] FORM_RM_REG  = 3'd0;
    localparam logic [2:0] FORM_IMM_RM  = 3'd1;
    localparam logic [2:0] FORM_IMM_REG = 3'd2;
    localparam logic [2:0] FORM_MEM_ACC = 3'd3;
    localparam logic [2:0] FORM_IMM_ACC = 3'd4;
    localparam logic [2:0] FORM_JUMP    = 3'd5;

    // opcode bases (low bits carry d/w/s, register or condition)
    localparam logic [7:0] OPC_MOV_RM      = 8'h88;
    localparam logic [7:0] OPC_ADD_RM      = 8'h00;
    localparam logic [7:0] OPC_SUB_RM      = 8'h28;
    localparam logic [7:0] OPC_CMP_RM      = 8'h38;
    localparam logic [7:0] OPC_MOV_IMM_RM  = 8'hC6;
    localparam logic [7:0] OPC_GRP1        = 8'h80;
    localparam logic [7:0] OPC_MOV_IMM_REG = 8'hB0;
    localparam logic [7:0] OPC_MOV_ACC     = 8'hA0;
    localparam logic [7:0] OPC_ADD_ACC     = 8'h04;
    localparam logic [7:0] OPC_SUB_ACC     = 8'h2C;
    localparam logic [7:0] OPC_CMP_ACC     = 8'h3C;
    localparam logic [7:0] OPC_JCC         = 8'h70;
    localparam logic [7:0] OPC_LOOP        = 8'hE0;

    localparam logic [7:0] MASK_PAIR   = 8'hFE;
    localparam logic [7:0] MASK_NIBBLE = 8'hF0;

    localparam logic [7:0] EXT_MASK  = 8'b0011_1000;
    localparam logic [7:0] EXT_ADD   = 8'b0000_0000;
    localparam logic [7:0] EXT_SUB   = 8'b0010_1000;
    localparam logic [7:0] EXT_CMP   = 8'b0011_1000;
    localparam logic [7:0] SIGN8     = 8'b1000_0000;
    localparam logic [7:0] OPC_MASK  = 8'b1111_1100;
    localparam logic [2:0] DIRECT_RM = 3'b110;

    // mod field of the modrm byte
    localparam logic [1:0] MOD_MEM    = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;

    // operation code per condition nibble of 0x70..0x7F
    localparam logic [4:0] JCC_OPS [16] = '{
        5'd10, 5'd18, 5'd7, 5'd15, 5'd4, 5'd12, 5'd8, 5'd16,
        5'd11, 5'd19, 5'd9, 5'd17, 5'd5, 5'd13, 5'd6, 5'd14
    };
    // loopnz, loopz, loop, jcxz for 0xE0..0xE3
    localparam logic [4:0] LOOP_OPS [4] = '{5'd22, 5'd21, 5'd20, 5'd23};

    typedef struct packed {
        logic       known;
        logic       has_modrm;
        logic       group;
        logic       sext;
        logic       bad_ext;
        logic [2:0] form;
        logic [4:0] operation;
        logic [1:0] disp_len;
        logic [1:0] imm_len;
    } layout_t;

    typedef struct packed {
        logic [4:0]  operation;
        logic [2:0]  form;
        logic        dest_is_reg;
        logic        wide;
        logic        sign_extend;
        logic [1:0]  mode_bits;
        logic [2:0]  reg_field;
        logic [2:0]  rm_field;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic [2:0]  length;
        logic        unknown_opcode;
    } record_t;

endpackage

[rtl/x86d_classify.sv]
// ----------------------------------------------------------------------------
// x86d_classify
// Opcode/modrm classification: form, operation and byte layout.
// ----------------------------------------------------------------------------
module x86d_classify (
    input  logic [7:0]        op,
    input  logic [7:0]        modrm,
    output x86d_pkg::layout_t layout
);
    import x86d_pkg::*;

    logic [1:0] disp_sz;
    logic [4:0] alu_from_op;
    logic       alu_op_bad;
    logic [4:0] alu_from_modrm;
    logic       alu_modrm_bad;
    logic [7:0] op_hi;

    assign op_hi = op & OPC_MASK;

    always_comb
    begin
        unique case (modrm[7:6])
            MOD_DISP8:  disp_sz = 2'd1;
            MOD_DISP16: disp_sz = 2'd2;
            MOD_MEM:    disp_sz = (modrm[2:0] == DIRECT_RM) ? 2'd2 : 2'd0;
            default:    disp_sz = 2'd0;
        endcase
    end

    always_comb
    begin
        alu_op_bad = 1'b0;
        if ((op & EXT_MASK) == EXT_ADD)
            alu_from_op = OP_ADD;
        else if ((op & EXT_MASK) == EXT_SUB)
            alu_from_op = OP_SUB;
        else if ((op & EXT_MASK) == EXT_CMP)
            alu_from_op = OP_CMP;
        else
        begin
            alu_from_op = OP_MOV;
            alu_op_bad  = 1'b1;
        end
    end

    always_comb
    begin
        alu_modrm_bad = 1'b0;
        if ((modrm & EXT_MASK) == EXT_ADD)
            alu_from_modrm = OP_ADD;
        else if ((modrm & EXT_MASK) == EXT_SUB)
            alu_from_modrm = OP_SUB;
        else if ((modrm & EXT_MASK) == EXT_CMP)
            alu_from_modrm = OP_CMP;
        else
        begin
            alu_from_modrm = OP_MOV;
            alu_modrm_bad  = 1'b1;
        end
    end

    always_comb
    begin
        layout       = '0;
        layout.known = 1'b1;
        if (op_hi == OPC_MOV_RM || op_hi == OPC_ADD_RM || op_hi == OPC_SUB_RM ||
            op_hi == OPC_CMP_RM)
        begin
            layout.form      = FORM_RM_REG;
            layout.has_modrm = 1'b1;
            layout.operation = (op_hi == OPC_MOV_RM) ? OP_MOV : alu_from_op;
            layout.bad_ext   = (op_hi == OPC_MOV_RM) ? 1'b0 : alu_op_bad;
            layout.disp_len  = disp_sz;
        end
        else if ((op & MASK_PAIR) == OPC_MOV_IMM_RM)
        begin
            // 0xC6/0xC7: reg field passed through unchecked
            layout.form      = FORM_IMM_RM;
            layout.has_modrm = 1'b1;
            layout.operation = OP_MOV;
            layout.disp_len  = disp_sz;
            layout.imm_len   = op[0] ? 2'd2 : 2'd1;
        end
        else if (op_hi == OPC_GRP1)
        begin
            layout.form      = FORM_IMM_RM;
            layout.has_modrm = 1'b1;
            layout.group     = 1'b1;
            layout.sext      = op[1];
            layout.operation = alu_from_modrm;
            layout.bad_ext   = alu_modrm_bad;
            layout.disp_len  = disp_sz;
            layout.imm_len   = (op[0] && !op[1]) ? 2'd2 : 2'd1;
        end
        else if ((op & MASK_NIBBLE) == OPC_MOV_IMM_REG)
        begin
            layout.form      = FORM_IMM_REG;
            layout.operation = OP_MOV;
            layout.imm_len   = op[3] ? 2'd2 : 2'd1;
        end
        else if (op_hi == OPC_MOV_ACC)
        begin
            layout.form      = FORM_MEM_ACC;
            layout.operation = OP_MOV;
            layout.disp_len  = 2'd2;
        end
        else if ((op & MASK_PAIR) == OPC_ADD_ACC || (op & MASK_PAIR) == OPC_SUB_ACC ||
                 (op & MASK_PAIR) == OPC_CMP_ACC)
        begin
            layout.form      = FORM_IMM_ACC;
            layout.operation = alu_from_op;
            layout.imm_len   = op[0] ? 2'd2 : 2'd1;
        end
        else if ((op & MASK_NIBBLE) == OPC_JCC)
        begin
            layout.form      = FORM_JUMP;
            layout.operation = JCC_OPS[op[3:0]];
            layout.imm_len   = 2'd1;
            layout.sext      = 1'b1;
        end
        else if (op_hi == OPC_LOOP)
        begin
            layout.form      = FORM_JUMP;
            layout.operation = LOOP_OPS[op[1:0]];
            layout.imm_len   = 2'd1;
            layout.sext      = 1'b1;
        end
        else
        begin
            layout.known = 1'b0;
        end
    end

endmodule

[rtl/x86d_out_buf.sv]
// ----------------------------------------------------------------------------
// x86d_out_buf
// Two-entry record queue that decouples the decoder from the output channel.
// ----------------------------------------------------------------------------
module x86d_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  x86d_pkg::record_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output x86d_pkg::record_t out_data
);
    import x86d_pkg::*;

    record_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;
    logic       do_push;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign do_push   = push && !full;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/x86_16bit_instruction_decoder.sv]
// ----------------------------------------------------------------------------
// x86_16bit_instruction_decoder
// Byte-serial 8086 subset decoder: one record per completed instruction.
// ----------------------------------------------------------------------------
// Takes one code byte per cycle while the output queue is not full.
// A record is written into the two-entry output queue when the instruction's last
// byte transfers, and is presented once the records ahead of it have been taken.
// Input stalls only when both queue entries hold records not yet taken.
// Asynchronous active-low reset: decoder waits for an opcode, queue empty.
module x86_16bit_instruction_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  code_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  operation,
    output logic [2:0]  form,
    output logic        dest_is_reg,
    output logic        wide,
    output logic        sign_extend,
    output logic [1:0]  mode_bits,
    output logic [2:0]  reg_field,
    output logic [2:0]  rm_field,
    output logic [15:0] displacement,
    output logic [15:0] immediate,
    output logic [2:0]  length,
    output logic        unknown_opcode
);
    import x86d_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic [2:0]  rem_reg, rem_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [15:0] disp_reg, disp_next;
    logic [15:0] imm_reg, imm_next;

    layout_t     lay_first;
    layout_t     lay_cur;
    logic [7:0]  modrm_eff;
    logic        accept;
    logic        buf_full;
    logic        emit;
    record_t     rec;
    record_t     out_rec;

    logic [2:0]  idx;
    logic [1:0]  imm_k;
    logic [15:0] byte_lo;
    logic [15:0] byte_hi;
    logic [15:0] disp_fin;
    logic [15:0] imm_fin;
    logic        rec_error;
    logic [2:0]  rec_len;

    assign in_ready  = !buf_full;
    assign accept    = in_valid && in_ready;
    assign modrm_eff = (pos_reg == 3'd1) ? code_byte : modrm_reg;

    x86d_classify u_cls_first (
        .op     (code_byte),
        .modrm  (8'h00),
        .layout (lay_first)
    );

    x86d_classify u_cls_cur (
        .op     (opcode_reg),
        .modrm  (modrm_eff),
        .layout (lay_cur)
    );

    assign idx     = pos_reg - 3'd1 - {2'b00, lay_cur.has_modrm};
    assign imm_k   = idx[1:0] - lay_cur.disp_len;
    assign byte_lo = {8'h00, code_byte};
    assign byte_hi = {code_byte, 8'h00};

    // byte sequencing
    always_comb
    begin
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        opcode_next = opcode_reg;
        modrm_next  = modrm_reg;
        disp_next   = disp_reg;
        imm_next    = imm_reg;
        emit        = 1'b0;
        rec_error   = 1'b0;
        rec_len     = 3'd0;
        if (pos_reg == 3'd0)
        begin
            opcode_next = code_byte;
            modrm_next  = 8'h00;
            disp_next   = 16'h0000;
            imm_next    = 16'h0000;
            if (!lay_first.known)
            begin
                emit      = 1'b1;
                rec_error = 1'b1;
                rec_len   = 3'd1;
                rem_next  = 3'd0;
            end
            else
            begin
                pos_next = 3'd1;
                rem_next = lay_first.has_modrm ? 3'd1
                         : {1'b0, lay_first.disp_len} + {1'b0, lay_first.imm_len};
            end
        end
        else if (lay_cur.has_modrm && pos_reg == 3'd1)
        begin
            modrm_next = code_byte;
            if (lay_cur.bad_ext)
            begin
                emit      = 1'b1;
                rec_error = 1'b1;
                rec_len   = 3'd2;
                pos_next  = 3'd0;
                rem_next  = 3'd0;
            end
            else
            begin
                rem_next = {1'b0, lay_cur.disp_len} + {1'b0, lay_cur.imm_len};
                pos_next = 3'd2;
                if (rem_next == 3'd0)
                begin
                    emit     = 1'b1;
                    rec_len  = 3'd2;
                    pos_next = 3'd0;
                end
            end
        end
        else
        begin
            if (idx < {1'b0, lay_cur.disp_len})
                disp_next = disp_reg | (idx[0] ? byte_hi : byte_lo);
            else
                imm_next = imm_reg | (imm_k[0] ? byte_hi : byte_lo);
            pos_next = pos_reg + 3'd1;
            rem_next = (rem_reg != 3'd0) ? rem_reg - 3'd1 : 3'd0;
            if (rem_next == 3'd0)
            begin
                emit     = 1'b1;
                rec_len  = pos_next;
                pos_next = 3'd0;
            end
        end
    end

    // record assembly
    always_comb
    begin
        disp_fin = disp_next;
        imm_fin  = imm_next;
        if (lay_cur.disp_len == 2'd1 && disp_fin[7])
            disp_fin = disp_fin | 16'hFF00;
        if (lay_cur.imm_len == 2'd1 && lay_cur.sext && imm_fin[7])
            imm_fin = imm_fin | 16'hFF00;
        if (lay_cur.form == FORM_JUMP)
            imm_fin = imm_fin + 16'd2;

        rec           = '0;
        rec.length    = rec_len;
        if (rec_error)
            rec.unknown_opcode = 1'b1;
        else
        begin
            rec.operation    = lay_cur.operation;
            rec.form         = lay_cur.form;
            rec.displacement = disp_fin;
            rec.immediate    = imm_fin;
            case (lay_cur.form)
                FORM_RM_REG, FORM_IMM_RM:
                begin
                    rec.dest_is_reg = (lay_cur.form == FORM_RM_REG) ? opcode_reg[1] : 1'b0;
                    rec.wide        = opcode_reg[0];
                    rec.sign_extend = lay_cur.group && opcode_reg[1];
                    rec.mode_bits   = modrm_eff[7:6];
                    rec.reg_field   = modrm_eff[5:3];
                    rec.rm_field    = modrm_eff[2:0];
                end
                FORM_IMM_REG:
                begin
                    rec.dest_is_reg = 1'b1;
                    rec.wide        = opcode_reg[3];
                    rec.reg_field   = opcode_reg[2:0];
                end
                FORM_MEM_ACC:
                begin
                    rec.dest_is_reg = !opcode_reg[1];
                    rec.wide        = opcode_reg[0];
                    rec.rm_field    = DIRECT_RM;
                end
                FORM_IMM_ACC:
                begin
                    rec.dest_is_reg = 1'b1;
                    rec.wide        = opcode_reg[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 3'd0;
            rem_reg    <= 3'd0;
            opcode_reg <= 8'h00;
            modrm_reg  <= 8'h00;
            disp_reg   <= 16'h0000;
            imm_reg    <= 16'h0000;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            rem_reg    <= rem_next;
            opcode_reg <= opcode_next;
            modrm_reg  <= modrm_next;
            disp_reg   <= disp_next;
            imm_reg    <= imm_next;
        end
    end

    x86d_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && emit),
        .push_data (rec),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_rec)
    );

    assign operation      = out_rec.operation;
    assign form           = out_rec.form;
    assign dest_is_reg    = out_rec.dest_is_reg;
    assign wide           = out_rec.wide;
    assign sign_extend    = out_rec.sign_extend;
    assign mode_bits      = out_rec.mode_bits;
    assign reg_field      = out_rec.reg_field;
    assign rm_field       = out_rec.rm_field;
    assign displacement   = out_rec.displacement;
    assign immediate      = out_rec.immediate;
    assign length         = out_rec.length;
    assign unknown_opcode = out_rec.unknown_opcode;

endmodule

[verif/x86d_record_checker.sv]
// ----------------------------------------------------------------------------
// x86d_record_checker
// Checker constants plus the record checker. The checker watches both
// channels, decodes each transferred code byte with its own byte-serial
// decoder and compares every record field by field against the oldest
// expected record.
// ----------------------------------------------------------------------------
package x86d_opcodes_pkg;

    localparam logic [4:0]  ALU_NONE   = 5'd31;
    localparam logic [15:0] JUMP_BIAS  = 16'd2;

endpackage

module x86d_record_checker
    import x86d_pkg::*;
    import x86d_opcodes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  code_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [4:0]  operation,
    input  logic [2:0]  form,
    input  logic        dest_is_reg,
    input  logic        wide,
    input  logic        sign_extend,
    input  logic [1:0]  mode_bits,
    input  logic [2:0]  reg_field,
    input  logic [2:0]  rm_field,
    input  logic [15:0] displacement,
    input  logic [15:0] immediate,
    input  logic [2:0]  length,
    input  logic        unknown_opcode,
    output int          fail_count,
    output int          pending,
    output int          records_seen,
    output int          unknown_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // decoder state, initialised to zero (not cleared by rst_n)
    logic [2:0]  pos       = '0;
    logic [7:0]  opc       = '0;
    logic [7:0]  mrm       = '0;
    logic [2:0]  remaining = '0;
    logic [15:0] disp_acc  = '0;
    logic [15:0] imm_acc   = '0;

    record_t expected_records[$];
    int      mismatches = 0;
    int      n_records  = 0;
    int      n_unknown  = 0;

    function automatic logic [4:0] alu_code(input logic [7:0] bits);
        logic [7:0] ext;
        ext = bits & EXT_MASK;
        if (ext == EXT_ADD)
            return OP_ADD;
        else if (ext == EXT_SUB)
            return OP_SUB;
        else if (ext == EXT_CMP)
            return OP_CMP;
        return ALU_NONE;
    endfunction

    function automatic logic [1:0] disp_bytes(input logic [7:0] modrm);
        case (modrm[7:6])
            MOD_DISP8:  return 2'd1;
            MOD_DISP16: return 2'd2;
            MOD_MEM:    return (modrm[2:0] == DIRECT_RM) ? 2'd2 : 2'd0;
            default:    return 2'd0;
        endcase
    endfunction

    function automatic layout_t classify(input logic [7:0] op, input logic [7:0] modrm);
        layout_t    d;
        logic [7:0] base;
        logic [4:0] alu;
        d       = '0;
        d.known = 1'b1;
        base    = op & OPC_MASK;
        if (base == OPC_MOV_RM || base == OPC_ADD_RM || base == OPC_SUB_RM ||
            base == OPC_CMP_RM)
        begin
            d.form      = FORM_RM_REG;
            d.has_modrm = 1'b1;
            d.operation = (base == OPC_MOV_RM) ? OP_MOV : alu_code(op);
            d.disp_len  = disp_bytes(modrm);
        end
        else if ((op & MASK_PAIR) == OPC_MOV_IMM_RM)
        begin
            d.form      = FORM_IMM_RM;
            d.has_modrm = 1'b1;
            d.operation = OP_MOV;
            d.disp_len  = disp_bytes(modrm);
            d.imm_len   = op[0] ? 2'd2 : 2'd1;
        end
        else if (base == OPC_GRP1)
        begin
            alu         = alu_code(modrm);
            d.form      = FORM_IMM_RM;
            d.has_modrm = 1'b1;
            d.group     = 1'b1;
            d.sext      = op[1];
            d.bad_ext   = (alu == ALU_NONE);
            d.operation = d.bad_ext ? OP_MOV : alu;
            d.disp_len  = disp_bytes(modrm);
            d.imm_len   = (op[0] && !op[1]) ? 2'd2 : 2'd1;
        end
        else if ((op & MASK_NIBBLE) == OPC_MOV_IMM_REG)
        begin
            d.form      = FORM_IMM_REG;
            d.operation = OP_MOV;
            d.imm_len   = op[3] ? 2'd2 : 2'd1;
        end
        else if (base == OPC_MOV_ACC)
        begin
            d.form      = FORM_MEM_ACC;
            d.operation = OP_MOV;
            d.disp_len  = 2'd2;
        end
        else if ((op & MASK_PAIR) == OPC_ADD_ACC || (op & MASK_PAIR) == OPC_SUB_ACC ||
                 (op & MASK_PAIR) == OPC_CMP_ACC)
        begin
            d.form      = FORM_IMM_ACC;
            d.operation = alu_code(op);
            d.imm_len   = op[0] ? 2'd2 : 2'd1;
        end
        else if ((op & MASK_NIBBLE) == OPC_JCC)
        begin
            d.form      = FORM_JUMP;
            d.operation = JCC_OPS[op[3:0]];
            d.imm_len   = 2'd1;
            d.sext      = 1'b1;
        end
        else if (base == OPC_LOOP)
        begin
            d.form      = FORM_JUMP;
            d.operation = LOOP_OPS[op[1:0]];
            d.imm_len   = 2'd1;
            d.sext      = 1'b1;
        end
        else
        begin
            d.known = 1'b0;
        end
        return d;
    endfunction

    task automatic push_error(input logic [2:0] len);
        record_t rec;
        rec                = '0;
        rec.length         = len;
        rec.unknown_opcode = 1'b1;
        pos                = '0;
        remaining          = '0;
        expected_records.push_back(rec);
    endtask

    task automatic push_record(input layout_t d);
        record_t     rec;
        logic [15:0] disp;
        logic [15:0] imm;
        rec  = '0;
        disp = disp_acc;
        imm  = imm_acc;
        if (d.disp_len == 2'd1 && disp[7])
            disp[15:8] = 8'hFF;
        if (d.imm_len == 2'd1 && d.sext && imm[7])
            imm[15:8] = 8'hFF;
        if (d.form == FORM_JUMP)
            imm = imm + JUMP_BIAS;
        rec.operation = d.operation;
        rec.form      = d.form;
        case (d.form)
            FORM_RM_REG, FORM_IMM_RM:
            begin
                rec.dest_is_reg = (d.form == FORM_RM_REG) ? opc[1] : 1'b0;
                rec.wide        = opc[0];
                rec.sign_extend = d.group && opc[1];
                rec.mode_bits   = mrm[7:6];
                rec.reg_field   = mrm[5:3];
                rec.rm_field    = mrm[2:0];
            end
            FORM_IMM_REG:
            begin
                rec.dest_is_reg = 1'b1;
                rec.wide        = opc[3];
                rec.reg_field   = opc[2:0];
            end
            FORM_MEM_ACC:
            begin
                rec.dest_is_reg = !opc[1];
                rec.wide        = opc[0];
                rec.rm_field    = DIRECT_RM;
            end
            FORM_IMM_ACC:
            begin
                rec.dest_is_reg = 1'b1;
                rec.wide        = opc[0];
            end
            default:
            begin
            end
        endcase
        rec.displacement = disp;
        rec.immediate    = imm;
        rec.length       = pos;
        pos              = '0;
        remaining        = '0;
        expected_records.push_back(rec);
    endtask

    // one code byte through the decoder; queues a record when one completes
    task automatic decode_byte(input logic [7:0] b);
        layout_t d;
        int      idx;
        int      k;
        if (pos == 3'd0)
        begin
            opc      = b;
            mrm      = '0;
            disp_acc = '0;
            imm_acc  = '0;
            d        = classify(b, 8'h00);
            if (!d.known)
                push_error(3'd1);
            else
            begin
                pos       = 3'd1;
                remaining = d.has_modrm ? 3'd1 : 3'(d.disp_len) + 3'(d.imm_len);
            end
        end
        else
        begin
            d = classify(opc, mrm);
            if (d.has_modrm && pos == 3'd1)
            begin
                mrm = b;
                d   = classify(opc, mrm);
                if (d.bad_ext)
                    push_error(3'd2);
                else
                begin
                    pos       = 3'd2;
                    remaining = 3'(d.disp_len) + 3'(d.imm_len);
                    if (remaining == 3'd0)
                        push_record(d);
                end
            end
            else
            begin
                idx = int'(pos) - 1 - int'(d.has_modrm);
                if (idx < int'(d.disp_len))
                    disp_acc = disp_acc | ({8'h00, b} << ((idx % 2) * 8));
                else
                begin
                    k       = (idx - int'(d.disp_len)) % 2;
                    imm_acc = imm_acc | ({8'h00, b} << (k * 8));
                end
                pos = pos + 3'd1;
                if (remaining > 3'd0)
                    remaining = remaining - 3'd1;
                if (remaining == 3'd0)
                    push_record(d);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        record_t want;
        if (rst_n)
        begin
            // record side first: a record never belongs to this edge's byte
            if (out_valid && out_ready)
            begin
                n_records++;
                if (unknown_opcode === 1'b1)
                    n_unknown++;
                if (expected_records.size() == 0)
                begin
                    $error("record transfer with no instruction outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_records.pop_front();
                    check_field("operation", 16'(want.operation), 16'(operation));
                    check_field("form", 16'(want.form), 16'(form));
                    check_field("dest_is_reg", 16'(want.dest_is_reg), 16'(dest_is_reg));
                    check_field("wide", 16'(want.wide), 16'(wide));
                    check_field("sign_extend", 16'(want.sign_extend), 16'(sign_extend));
                    check_field("mode_bits", 16'(want.mode_bits), 16'(mode_bits));
                    check_field("reg_field", 16'(want.reg_field), 16'(reg_field));
                    check_field("rm_field", 16'(want.rm_field), 16'(rm_field));
                    check_field("displacement", want.displacement, displacement);
                    check_field("immediate", want.immediate, immediate);
                    check_field("length", 16'(want.length), 16'(length));
                    check_field("unknown_opcode", 16'(want.unknown_opcode),
                                16'(unknown_opcode));
                end
            end
            if (in_valid && in_ready)
                decode_byte(code_byte);
            fail_count   <= mismatches;
            pending      <= expected_records.size();
            records_seen <= n_records;
            unknown_seen <= n_unknown;
        end
    end

endmodule

[verif/x86_16bit_instruction_decoder_test.sv]
// ----------------------------------------------------------------------------
// x86_16bit_instruction_decoder_test
// Feeds the decoder a short hand-built code stream, then random instruction
// streams (mostly well-formed, some truncated or noise bytes) under three
// flow-control mixes; the record checker verifies every record.
// ----------------------------------------------------------------------------
module x86_16bit_instruction_decoder_test;
    import x86d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  code_byte;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [4:0]  operation;
    logic [2:0]  form;
    logic        dest_is_reg;
    logic        wide;
    logic        sign_extend;
    logic [1:0]  mode_bits;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [2:0]  length;
    logic        unknown_opcode;

    int fail_count;
    int pending;
    int records_seen;
    int unknown_seen;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;
    logic [7:0] instr_q[$];

    x86_16bit_instruction_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .code_byte      (code_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .operation      (operation),
        .form           (form),
        .dest_is_reg    (dest_is_reg),
        .wide           (wide),
        .sign_extend    (sign_extend),
        .mode_bits      (mode_bits),
        .reg_field      (reg_field),
        .rm_field       (rm_field),
        .displacement   (displacement),
        .immediate      (immediate),
        .length         (length),
        .unknown_opcode (unknown_opcode)
    );

    x86d_record_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .code_byte      (code_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .operation      (operation),
        .form           (form),
        .dest_is_reg    (dest_is_reg),
        .wide           (wide),
        .sign_extend    (sign_extend),
        .mode_bits      (mode_bits),
        .reg_field      (reg_field),
        .rm_field       (rm_field),
        .displacement   (displacement),
        .immediate      (immediate),
        .length         (length),
        .unknown_opcode (unknown_opcode),
        .fail_count     (fail_count),
        .pending        (pending),
        .records_seen   (records_seen),
        .unknown_seen   (unknown_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        code_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_queue();
        while (instr_q.size() > 0)
            send_byte(instr_q.pop_front());
    endtask

    // one instruction, mostly well-formed, into instr_q
    task automatic queue_instruction();
        int         pick;
        int         n_disp;
        int         n_imm;
        int         n_drop;
        logic       has_mrm;
        logic [7:0] op;
        logic [7:0] mrm;
        logic [7:0] ext;
        pick    = $urandom_range(99);
        n_disp  = 0;
        n_imm   = 0;
        has_mrm = 1'b0;
        mrm     = 8'($urandom_range(255));
        op      = 8'($urandom_range(255));
        if (pick < 20)
        begin
            case ($urandom_range(3))
                0:       op = OPC_MOV_RM;
                1:       op = OPC_ADD_RM;
                2:       op = OPC_SUB_RM;
                default: op = OPC_CMP_RM;
            endcase
            op[1:0] = 2'($urandom_range(3));
            has_mrm = 1'b1;
        end
        else if (pick < 28)
        begin
            op      = OPC_MOV_IMM_RM;
            op[0]   = 1'($urandom_range(1));
            has_mrm = 1'b1;
            n_imm   = op[0] ? 2 : 1;
        end
        else if (pick < 42)
        begin
            op      = OPC_GRP1;
            op[1:0] = 2'($urandom_range(3));
            has_mrm = 1'b1;
            // mostly add/sub/cmp; the rest keeps a random extension
            if ($urandom_range(4) != 0)
            begin
                case ($urandom_range(2))
                    0:       ext = EXT_ADD;
                    1:       ext = EXT_SUB;
                    default: ext = EXT_CMP;
                endcase
                mrm = (mrm & ~EXT_MASK) | ext;
            end
            n_imm = (op[0] && !op[1]) ? 2 : 1;
        end
        else if (pick < 52)
        begin
            op      = OPC_MOV_IMM_REG;
            op[3:0] = 4'($urandom_range(15));
            n_imm   = op[3] ? 2 : 1;
        end
        else if (pick < 58)
        begin
            op      = OPC_MOV_ACC;
            op[1:0] = 2'($urandom_range(3));
            n_disp  = 2;
        end
        else if (pick < 68)
        begin
            case ($urandom_range(2))
                0:       op = OPC_ADD_ACC;
                1:       op = OPC_SUB_ACC;
                default: op = OPC_CMP_ACC;
            endcase
            op[0] = 1'($urandom_range(1));
            n_imm = op[0] ? 2 : 1;
        end
        else if (pick < 82)
        begin
            op      = OPC_JCC;
            op[3:0] = 4'($urandom_range(15));
            n_imm   = 1;
        end
        else if (pick < 90)
        begin
            op      = OPC_LOOP;
            op[1:0] = 2'($urandom_range(3));
            n_imm   = 1;
        end
        // else: a lone random byte
        instr_q.push_back(op);
        if (has_mrm)
        begin
            instr_q.push_back(mrm);
            case (mrm[7:6])
                MOD_DISP8:  n_disp = 1;
                MOD_DISP16: n_disp = 2;
                MOD_MEM:    n_disp = (mrm[2:0] == DIRECT_RM) ? 2 : 0;
                default:    n_disp = 0;
            endcase
        end
        repeat (n_disp + n_imm)
            instr_q.push_back(8'($urandom_range(255)));
        // occasionally cut the instruction short
        if ($urandom_range(19) == 0 && instr_q.size() > 1)
        begin
            n_drop = $urandom_range(instr_q.size() - 1, 1);
            repeat (n_drop)
                void'(instr_q.pop_back());
        end
    endtask

    task automatic fill_until(input int target);
        while (bytes_sent < target)
        begin
            queue_instruction();
            send_queue();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        code_byte = 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 19;
        rx_idle_pct <= 61;
        instr_q = '{
            8'hFF,                                          // unimplemented opcode
            OPC_GRP1, 8'hC8,                                // group with or extension
            OPC_GRP1 | 8'h03, 8'h46, 8'h80, 8'hFF,          // add word [bp-128], -1
            OPC_MOV_IMM_RM | 8'h01, 8'h3E, 8'hFF, 8'hFF,    // mov [0xFFFF] with reg 7,
            8'h00, 8'h80,                                   //   word 0x8000
            OPC_JCC | 8'h05, 8'hFE,                         // jne back onto itself
            OPC_JCC | 8'h0F, 8'h7F,                         // jg farthest forward
            OPC_LOOP | 8'h03, 8'h80,                        // jcxz farthest back
            OPC_MOV_ACC | 8'h01, 8'h00, 8'h00,              // mov ax, [0]
            OPC_CMP_ACC, 8'hFF,                             // byte data not sign-extended
            OPC_SUB_RM | 8'h03, 8'hFF                       // register-to-register
        };
        send_queue();
        fill_until(650);

        tx_idle_pct = 61;
        rx_idle_pct <= 19;
        fill_until(1300);

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        fill_until(1950);
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending != 0)
            $error("%0d expected records never arrived", pending);
        $display("Decoded %0d code bytes into %0d records, %0d of them unknown-opcode.",
                 bytes_sent, records_seen, unknown_seen);
        $display("Flow control: slow receiver, then slow sender, then back-to-back.");
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
